### rtl/bsfn_pkg.sv
// shared types and constants for the bit map store with find-next
package bsfn_pkg;

  localparam int unsigned REQ_W  = 4;
  localparam int unsigned IDX_W  = 13;
  localparam int unsigned REQB_W = 13;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned SIZE_W = 12;

  typedef enum logic [REQ_W-1:0] {
    REQ_TEST       = 4'd0,
    REQ_SET        = 4'd1,
    REQ_CLEAR      = 4'd2,
    REQ_SET_ALL    = 4'd3,
    REQ_CLEAR_ALL  = 4'd4,
    REQ_COMPLEMENT = 4'd5,
    REQ_FIND_SET   = 4'd6,
    REQ_FIND_ZERO  = 4'd7,
    REQ_RESIZE     = 4'd8
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_BIT,
    ST_FILL,
    ST_CMPL,
    ST_FIND,
    ST_GROW,
    ST_SIZE,
    ST_DONE
  } state_e;

endpackage

### rtl/bsfn_if.sv
// request and response channel interfaces
interface bsfn_req_if;
  logic                                valid;
  logic                                ready;
  logic [bsfn_pkg::REQ_W-1:0]          req_type;
  logic signed [bsfn_pkg::IDX_W-1:0]   bit_index;
  logic [bsfn_pkg::REQB_W-1:0]         requested_bits;

  modport source (output valid, req_type, bit_index, requested_bits, input ready);
  modport sink   (input valid, req_type, bit_index, requested_bits, output ready);
endinterface

interface bsfn_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          bit_value;
  logic [bsfn_pkg::POS_W-1:0]    found_position;
  logic [bsfn_pkg::SIZE_W-1:0]   size_bits;

  modport source (output valid, bit_value, found_position, size_bits, input ready);
  modport sink   (input valid, bit_value, found_position, size_bits, output ready);
endinterface

### rtl/bsfn_word_ram.sv
// word store: one write port, one read port with registered read data
module bsfn_word_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bitmap_store_find_next.sv
// bit map store with test/set/clear, whole-map operations, find-next and resize
// steps: accept, decode, per-kind state, done, output register; bit requests read one word
//   and set/clear write it back (not if out of range), resize zeroes newly exposed words,
//   whole-map ops sweep the live words; finds scan live_words - start word words at most
// one transaction at a time: ready returns as the result is registered
// reset clears control state and the live size; words are zeroed as a resize exposes them
module bitmap_store_find_next #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned MAX_WORDS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bsfn_req_if.sink     req_i,
  bsfn_rsp_if.source   rsp_o
);

  localparam int unsigned AW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned PW     = $clog2(MAX_WORDS + 1);
  localparam int unsigned LB_W   = $clog2(MAX_WORDS * WORD_BITS + 1);
  localparam int unsigned OFF_W  = $clog2(WORD_BITS);
  // reciprocal divide by WORD_BITS, exact for 14-bit dividends
  localparam int unsigned DIV_N  = 14;
  localparam int unsigned DIV_L  = $clog2(WORD_BITS);
  localparam int unsigned DIV_SH = DIV_N + DIV_L;
  localparam int unsigned DIV_PW = 2 * DIV_N + 1;
  localparam int unsigned QW     = DIV_N - DIV_L + 1;
  localparam logic [DIV_N:0] RECIP =
      (DIV_N + 1)'(((64'd1 << DIV_SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
  localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

  bsfn_pkg::state_e state_q, state_d;
  bsfn_pkg::req_e   req_q, req_d;

  logic                          neg_q, neg_d;
  logic [bsfn_pkg::POS_W-1:0]    idx_nn_q, idx_nn_d;
  logic [QW-1:0]                 quot_q, quot_d;
  logic [OFF_W-1:0]              off_q, off_d;
  logic [LB_W-1:0]               base_q, base_d;
  logic [PW-1:0]                 ptr_q, ptr_d;
  logic [PW-1:0]                 end_q, end_d;
  logic                          first_q, first_d;
  logic                          pend_bit_q, pend_bit_d;
  logic [bsfn_pkg::POS_W-1:0]    pend_found_q, pend_found_d;
  logic [PW-1:0]                 live_words_q, live_words_d;
  logic [LB_W-1:0]               live_bits_q, live_bits_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_bit_q, out_bit_d;
  logic [bsfn_pkg::POS_W-1:0]    out_found_q, out_found_d;
  logic [bsfn_pkg::SIZE_W-1:0]   out_size_q, out_size_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [DIV_N-1:0]     div_in;
  logic [DIV_PW-1:0]    div_prod;
  logic                 req_fire;

  // scan word with the start offset applied, and its lowest set bit
  logic [WORD_BITS-1:0] scan_word;
  logic                 scan_hit;
  logic [OFF_W-1:0]     scan_low;

  assign req_fire = req_i.valid && req_i.ready;

  // accept-cycle divide: bit index for bit and find requests, rounded size for resize
  always_comb begin
    if (bsfn_pkg::req_e'(req_i.req_type) == bsfn_pkg::REQ_RESIZE) begin
      div_in = DIV_N'(req_i.requested_bits) + DIV_N'(WORD_BITS - 1);
    end else if (req_i.bit_index[bsfn_pkg::IDX_W-1]) begin
      div_in = '0;
    end else begin
      div_in = DIV_N'(req_i.bit_index[bsfn_pkg::POS_W-1:0]);
    end
    div_prod = DIV_PW'(div_in) * DIV_PW'(RECIP);
  end

  always_comb begin
    if (req_q == bsfn_pkg::REQ_FIND_SET) begin
      scan_word = ram_rdata;
    end else begin
      scan_word = ~ram_rdata;
    end
    if (first_q) begin
      scan_word = scan_word & (ALL_ONES << off_q);
    end
    scan_hit = |scan_word;
    scan_low = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (scan_word[i]) begin
        scan_low = OFF_W'(i);
      end
    end
  end

  always_comb begin
    logic [PW-1:0]  nw;
    logic [31:0]    prod;
    logic [PW-1:0]  ptr_nx;

    state_d      = state_q;
    req_d        = req_q;
    neg_d        = neg_q;
    idx_nn_d     = idx_nn_q;
    quot_d       = quot_q;
    off_d        = off_q;
    base_d       = base_q;
    ptr_d        = ptr_q;
    end_d        = end_q;
    first_d      = first_q;
    pend_bit_d   = pend_bit_q;
    pend_found_d = pend_found_q;
    live_words_d = live_words_q;
    live_bits_d  = live_bits_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_bit_d    = out_bit_q;
    out_found_d  = out_found_q;
    out_size_d   = out_size_q;

    ram_we    = 1'b0;
    ram_waddr = AW'(ptr_q);
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = AW'(ptr_q);

    req_i.ready = (state_q == bsfn_pkg::ST_IDLE);

    if (32'(quot_q) > 32'(MAX_WORDS)) begin
      nw = PW'(MAX_WORDS);
    end else begin
      nw = PW'(quot_q);
    end
    prod   = 32'(quot_q) * 32'(WORD_BITS);
    ptr_nx = ptr_q + PW'(1);

    case (state_q)
      bsfn_pkg::ST_IDLE: begin
        if (req_fire) begin
          req_d  = bsfn_pkg::req_e'(req_i.req_type);
          neg_d  = req_i.bit_index[bsfn_pkg::IDX_W-1];
          if (req_i.bit_index[bsfn_pkg::IDX_W-1]) begin
            idx_nn_d = '0;
          end else begin
            idx_nn_d = req_i.bit_index[bsfn_pkg::POS_W-1:0];
          end
          quot_d  = div_prod[DIV_SH +: QW];
          state_d = bsfn_pkg::ST_DECODE;
        end
      end

      bsfn_pkg::ST_DECODE: begin
        off_d        = OFF_W'(32'(idx_nn_q) - prod);
        base_d       = LB_W'(prod);
        pend_bit_d   = 1'b0;
        pend_found_d = '0;
        first_d      = 1'b1;
        state_d      = bsfn_pkg::ST_DONE;
        case (req_q)
          bsfn_pkg::REQ_TEST, bsfn_pkg::REQ_SET, bsfn_pkg::REQ_CLEAR: begin
            if (!neg_q && 32'(idx_nn_q) < 32'(live_bits_q)) begin
              ram_re    = 1'b1;
              ram_raddr = AW'(quot_q);
              ptr_d     = PW'(quot_q);
              state_d   = bsfn_pkg::ST_BIT;
            end
          end
          bsfn_pkg::REQ_SET_ALL, bsfn_pkg::REQ_CLEAR_ALL: begin
            ptr_d = '0;
            if (live_words_q != '0) begin
              state_d = bsfn_pkg::ST_FILL;
            end
          end
          bsfn_pkg::REQ_COMPLEMENT: begin
            ptr_d = '0;
            if (live_words_q != '0) begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_d   = bsfn_pkg::ST_CMPL;
            end
          end
          bsfn_pkg::REQ_FIND_SET, bsfn_pkg::REQ_FIND_ZERO: begin
            if (32'(idx_nn_q) < 32'(live_bits_q)) begin
              ram_re    = 1'b1;
              ram_raddr = AW'(quot_q);
              ptr_d     = PW'(quot_q);
              state_d   = bsfn_pkg::ST_FIND;
            end
          end
          bsfn_pkg::REQ_RESIZE: begin
            end_d = nw;
            ptr_d = live_words_q;
            if (nw > live_words_q) begin
              state_d = bsfn_pkg::ST_GROW;
            end else begin
              state_d = bsfn_pkg::ST_SIZE;
            end
          end
          default: begin
            state_d = bsfn_pkg::ST_DONE;
          end
        endcase
      end

      bsfn_pkg::ST_BIT: begin
        ram_waddr = AW'(ptr_q);
        case (req_q)
          bsfn_pkg::REQ_SET: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | (WORD_BITS'(1) << off_q);
          end
          bsfn_pkg::REQ_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~(WORD_BITS'(1) << off_q);
          end
          default: begin
            pend_bit_d = ram_rdata[off_q];
          end
        endcase
        state_d = bsfn_pkg::ST_DONE;
      end

      bsfn_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = (req_q == bsfn_pkg::REQ_SET_ALL) ? ALL_ONES : '0;
        ptr_d     = ptr_nx;
        if (ptr_nx == live_words_q) begin
          state_d = bsfn_pkg::ST_DONE;
        end
      end

      bsfn_pkg::ST_CMPL: begin
        // write word ptr while reading word ptr + 1
        ram_we    = 1'b1;
        ram_wdata = ~ram_rdata;
        ptr_d     = ptr_nx;
        if (ptr_nx == live_words_q) begin
          state_d = bsfn_pkg::ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ptr_nx);
        end
      end

      bsfn_pkg::ST_FIND: begin
        first_d = 1'b0;
        if (scan_hit) begin
          pend_found_d = bsfn_pkg::POS_W'(32'(base_q) + 32'(scan_low) + 32'd1);
          state_d      = bsfn_pkg::ST_DONE;
        end else if (ptr_nx == live_words_q) begin
          state_d = bsfn_pkg::ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ptr_nx);
          ptr_d     = ptr_nx;
          base_d    = base_q + LB_W'(WORD_BITS);
        end
      end

      bsfn_pkg::ST_GROW: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        ptr_d     = ptr_nx;
        if (ptr_nx == end_q) begin
          state_d = bsfn_pkg::ST_SIZE;
        end
      end

      bsfn_pkg::ST_SIZE: begin
        live_words_d = end_q;
        live_bits_d  = LB_W'(32'(end_q) * 32'(WORD_BITS));
        state_d      = bsfn_pkg::ST_DONE;
      end

      bsfn_pkg::ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_bit_d   = pend_bit_q;
          out_found_d = pend_found_q;
          out_size_d  = bsfn_pkg::SIZE_W'(live_bits_q);
          state_d     = bsfn_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bsfn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bsfn_pkg::ST_IDLE;
      live_words_q <= '0;
      live_bits_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      live_words_q <= live_words_d;
      live_bits_q  <= live_bits_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    neg_q        <= neg_d;
    idx_nn_q     <= idx_nn_d;
    quot_q       <= quot_d;
    off_q        <= off_d;
    base_q       <= base_d;
    ptr_q        <= ptr_d;
    end_q        <= end_d;
    first_q      <= first_d;
    pend_bit_q   <= pend_bit_d;
    pend_found_q <= pend_found_d;
    out_bit_q    <= out_bit_d;
    out_found_q  <= out_found_d;
    out_size_q   <= out_size_d;
  end

  bsfn_word_ram #(
    .DATA_W (WORD_BITS),
    .DEPTH  (MAX_WORDS),
    .ADDR_W (AW)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.bit_value      = out_bit_q;
  assign rsp_o.found_position = out_found_q;
  assign rsp_o.size_bits      = out_size_q;

  a_live_words_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(live_words_q) <= 32'(MAX_WORDS))
    else $error("live word count above capacity");

  a_live_bits_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsfn_pkg::ST_IDLE) |->
      32'(live_bits_q) == 32'(live_words_q) * 32'(WORD_BITS))
    else $error("live bit count out of step with live word count");

  a_write_states : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == bsfn_pkg::ST_BIT || state_q == bsfn_pkg::ST_FILL ||
                state_q == bsfn_pkg::ST_CMPL || state_q == bsfn_pkg::ST_GROW))
    else $error("word write outside a write state");

  a_size_change : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(live_words_q) |-> $past(state_q == bsfn_pkg::ST_SIZE))
    else $error("live size changed outside resize");

  a_accept_decode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == bsfn_pkg::ST_DECODE))
    else $error("accepted transaction not decoded");

endmodule
